### rtl/core/ehp_pkg.sv
// Shared types and constants for the Ethernet/IP header parser.
// No dependencies; ehp_parse, ehp_outq, the top and the testbench refer to this package.
`default_nettype none

package ehp_pkg;

  // Field tags carried on each result transfer
  localparam logic [4:0] TAG_DST_MAC     = 5'd0;
  localparam logic [4:0] TAG_SRC_MAC     = 5'd1;
  localparam logic [4:0] TAG_VLAN_ID     = 5'd2;
  localparam logic [4:0] TAG_IP4_SRC     = 5'd3;
  localparam logic [4:0] TAG_IP4_DST     = 5'd4;
  localparam logic [4:0] TAG_IP_PROTO    = 5'd5;
  localparam logic [4:0] TAG_TTL         = 5'd6;
  localparam logic [4:0] TAG_TOTAL_LEN   = 5'd7;
  localparam logic [4:0] TAG_IDENT       = 5'd8;
  localparam logic [4:0] TAG_IP6_SRC_HI  = 5'd9;
  localparam logic [4:0] TAG_IP6_SRC_LO  = 5'd10;
  localparam logic [4:0] TAG_IP6_DST_HI  = 5'd11;
  localparam logic [4:0] TAG_IP6_DST_LO  = 5'd12;
  localparam logic [4:0] TAG_HOP_LIMIT   = 5'd13;
  localparam logic [4:0] TAG_PAYLOAD_LEN = 5'd14;
  localparam logic [4:0] TAG_L4_SRC_PORT = 5'd15;
  localparam logic [4:0] TAG_L4_DST_PORT = 5'd16;
  localparam logic [4:0] TAG_UDP_LEN     = 5'd17;
  localparam logic [4:0] TAG_TCP_FLAGS   = 5'd18;
  localparam logic [4:0] TAG_TCP_WINDOW  = 5'd19;
  localparam logic [4:0] TAG_TCP_HDR_LEN = 5'd20;
  localparam logic [4:0] TAG_ICMP_TYPE   = 5'd21;
  localparam logic [4:0] TAG_ICMP_CODE   = 5'd22;
  localparam logic [4:0] TAG_IGMP_TYPE   = 5'd23;
  localparam logic [4:0] TAG_IGMP_GROUP  = 5'd24;
  localparam logic [4:0] TAG_END         = 5'd25;

  // Parse status on the end record
  localparam logic [1:0] PSTAT_OK      = 2'd0;
  localparam logic [1:0] PSTAT_TRUNC   = 2'd1;
  localparam logic [1:0] PSTAT_UNSUPP  = 2'd2;
  localparam logic [1:0] PSTAT_BAD_IHL = 2'd3;

  // Ethertypes and IP protocol numbers
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_IGMP = 8'd2;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IHL_MIN    = 4'd5;

  // Result queue depth; must hold the two results one byte can cause
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic [4:0]  tag;
    logic [63:0] value;
    logic [1:0]  status;
    logic        last;
  } ehp_result_t;

  // Results caused by one accepted byte, in order
  typedef struct packed {
    ehp_result_t first;
    ehp_result_t second;
    logic [1:0]  count;
  } ehp_batch_t;

endpackage

`default_nettype wire

### rtl/core/ehp_in_if.sv
// Byte channel into the header parser: valid/ready plus one frame byte.
// Standalone interface, no package dependency.
`default_nettype none

interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/core/ehp_out_if.sv
// Result channel out of the header parser: valid/ready plus one tagged field.
// Standalone interface, no package dependency.
`default_nettype none

interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_tag;
  logic [63:0] field_value;
  logic [1:0]  parse_status;
  logic        run_last;

  modport source (output valid, output field_tag, output field_value,
                  output parse_status, output run_last, input ready);
  modport sink   (input valid, input field_tag, input field_value,
                  input parse_status, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/core/ehp_parse.sv
// Byte-serial parse state and field extraction for the header parser.
// Depends on ehp_pkg for tags, status codes and the batch type.
`default_nettype none

module ehp_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        data_byte,
  input  wire logic              frame_end,
  output ehp_pkg::ehp_batch_t    batch
);

  typedef enum logic [2:0] {
    STG_ETH, STG_VLAN, STG_IP4, STG_IP6, STG_L4, STG_DONE
  } stage_t;

  typedef enum logic [2:0] {
    TK_NONE, TK_TCP, TK_UDP, TK_ICMP, TK_IGMP
  } tkind_t;

  stage_t      stage, stage_next;
  logic [6:0]  idx, idx_next;
  logic [63:0] facc;
  logic [5:0]  ihb, ihb_next;
  tkind_t      tkind, tkind_next;
  logic [1:0]  status, status_next;

  logic [63:0] acc;
  logic [15:0] ekind;
  logic        adv;
  logic        jump;
  logic        fld_valid;
  logic [4:0]  fld_tag;
  logic [63:0] fld_value;
  logic [1:0]  end_status;
  ehp_pkg::ehp_result_t fld_res, end_res;

  assign acc   = {facc[55:0], data_byte};
  assign ekind = acc[15:0];

  // Decode one byte against the current header position
  always_comb begin
    stage_next  = stage;
    ihb_next    = ihb;
    tkind_next  = tkind;
    status_next = status;
    adv         = 1'b1;
    jump        = 1'b0;
    fld_valid   = 1'b0;
    fld_tag     = ehp_pkg::TAG_END;
    fld_value   = '0;

    unique case (stage)
      STG_ETH: begin
        if (idx == 7'd5) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_DST_MAC;
          fld_value = {16'd0, acc[47:0]};
        end else if (idx == 7'd11) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_SRC_MAC;
          fld_value = {16'd0, acc[47:0]};
        end else if (idx == 7'd13) begin
          jump = 1'b1;
          priority if (ekind == ehp_pkg::ETYPE_VLAN) stage_next = STG_VLAN;
          else if (ekind == ehp_pkg::ETYPE_IPV4) stage_next = STG_IP4;
          else if (ekind == ehp_pkg::ETYPE_IPV6) stage_next = STG_IP6;
          else begin
            stage_next = STG_DONE;
            if (status == ehp_pkg::PSTAT_OK) status_next = ehp_pkg::PSTAT_UNSUPP;
          end
        end
      end

      STG_VLAN: begin
        if (idx == 7'd1) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_VLAN_ID;
          fld_value = {52'd0, acc[11:0]};
        end else if (idx == 7'd3) begin
          // A second tag is not accepted
          jump = 1'b1;
          priority if (ekind == ehp_pkg::ETYPE_IPV4) stage_next = STG_IP4;
          else if (ekind == ehp_pkg::ETYPE_IPV6) stage_next = STG_IP6;
          else begin
            stage_next = STG_DONE;
            if (status == ehp_pkg::PSTAT_OK) status_next = ehp_pkg::PSTAT_UNSUPP;
          end
        end
      end

      STG_IP4: begin
        if (idx == 7'd0) begin
          ihb_next = {data_byte[3:0], 2'b00};
          if (data_byte[3:0] < ehp_pkg::IHL_MIN) status_next = ehp_pkg::PSTAT_BAD_IHL;
        end else if (idx == 7'd3) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_TOTAL_LEN;
          fld_value = {48'd0, acc[15:0]};
        end else if (idx == 7'd5) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IDENT;
          fld_value = {48'd0, acc[15:0]};
        end else if (idx == 7'd8) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_TTL;
          fld_value = {56'd0, data_byte};
        end else if (idx == 7'd9) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP_PROTO;
          fld_value = {56'd0, data_byte};
          priority if (data_byte == ehp_pkg::PROTO_TCP) tkind_next = TK_TCP;
          else if (data_byte == ehp_pkg::PROTO_UDP) tkind_next = TK_UDP;
          else if (data_byte == ehp_pkg::PROTO_ICMP) tkind_next = TK_ICMP;
          else if (data_byte == ehp_pkg::PROTO_IGMP) tkind_next = TK_IGMP;
          else tkind_next = TK_NONE;
        end else if (idx == 7'd15) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP4_SRC;
          fld_value = {32'd0, acc[31:0]};
        end else if (idx == 7'd19) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP4_DST;
          fld_value = {32'd0, acc[31:0]};
        end
        // Leave the header once options are skipped; bad IHL stops here
        if (idx >= 7'd19) begin
          if (status == ehp_pkg::PSTAT_BAD_IHL) begin
            jump       = 1'b1;
            stage_next = STG_DONE;
          end else if ({1'b0, idx} + 8'd1 >= {2'b00, ihb}) begin
            jump = 1'b1;
            if (tkind == TK_NONE) begin
              stage_next = STG_DONE;
              if (status == ehp_pkg::PSTAT_OK) status_next = ehp_pkg::PSTAT_UNSUPP;
            end else begin
              stage_next = STG_L4;
            end
          end
        end
      end

      STG_IP6: begin
        if (idx == 7'd5) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_PAYLOAD_LEN;
          fld_value = {48'd0, acc[15:0]};
        end else if (idx == 7'd6) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP_PROTO;
          fld_value = {56'd0, data_byte};
          priority if (data_byte == ehp_pkg::PROTO_TCP) tkind_next = TK_TCP;
          else if (data_byte == ehp_pkg::PROTO_UDP) tkind_next = TK_UDP;
          else tkind_next = TK_NONE;
        end else if (idx == 7'd7) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_HOP_LIMIT;
          fld_value = {56'd0, data_byte};
        end else if (idx == 7'd15) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP6_SRC_HI;
          fld_value = acc;
        end else if (idx == 7'd23) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP6_SRC_LO;
          fld_value = acc;
        end else if (idx == 7'd31) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP6_DST_HI;
          fld_value = acc;
        end else if (idx == 7'd39) begin
          fld_valid = 1'b1;
          fld_tag   = ehp_pkg::TAG_IP6_DST_LO;
          fld_value = acc;
          jump      = 1'b1;
          if (tkind == TK_NONE) begin
            stage_next = STG_DONE;
            if (status == ehp_pkg::PSTAT_OK) status_next = ehp_pkg::PSTAT_UNSUPP;
          end else begin
            stage_next = STG_L4;
          end
        end
      end

      STG_L4: begin
        if (tkind == TK_TCP || tkind == TK_UDP) begin
          if (idx == 7'd1) begin
            fld_valid = 1'b1;
            fld_tag   = ehp_pkg::TAG_L4_SRC_PORT;
            fld_value = {48'd0, acc[15:0]};
          end else if (idx == 7'd3) begin
            fld_valid = 1'b1;
            fld_tag   = ehp_pkg::TAG_L4_DST_PORT;
            fld_value = {48'd0, acc[15:0]};
          end else if (tkind == TK_UDP && idx == 7'd5) begin
            fld_valid  = 1'b1;
            fld_tag    = ehp_pkg::TAG_UDP_LEN;
            fld_value  = {48'd0, acc[15:0]};
            jump       = 1'b1;
            stage_next = STG_DONE;
          end else if (tkind == TK_TCP && idx == 7'd12) begin
            fld_valid = 1'b1;
            fld_tag   = ehp_pkg::TAG_TCP_HDR_LEN;
            fld_value = {58'd0, data_byte[7:4], 2'b00};
          end else if (tkind == TK_TCP && idx == 7'd13) begin
            fld_valid = 1'b1;
            fld_tag   = ehp_pkg::TAG_TCP_FLAGS;
            fld_value = {56'd0, data_byte};
          end else if (tkind == TK_TCP && idx == 7'd15) begin
            fld_valid  = 1'b1;
            fld_tag    = ehp_pkg::TAG_TCP_WINDOW;
            fld_value  = {48'd0, acc[15:0]};
            jump       = 1'b1;
            stage_next = STG_DONE;
          end
        end else if (tkind == TK_ICMP) begin
          if (idx == 7'd0) begin
            fld_valid = 1'b1;
            fld_tag   = ehp_pkg::TAG_ICMP_TYPE;
            fld_value = {56'd0, data_byte};
          end else if (idx == 7'd1) begin
            fld_valid  = 1'b1;
            fld_tag    = ehp_pkg::TAG_ICMP_CODE;
            fld_value  = {56'd0, data_byte};
            jump       = 1'b1;
            stage_next = STG_DONE;
          end
        end else if (tkind == TK_IGMP) begin
          if (idx == 7'd0) begin
            fld_valid = 1'b1;
            fld_tag   = ehp_pkg::TAG_IGMP_TYPE;
            fld_value = {56'd0, data_byte};
          end else if (idx == 7'd7) begin
            fld_valid  = 1'b1;
            fld_tag    = ehp_pkg::TAG_IGMP_GROUP;
            fld_value  = {32'd0, acc[31:0]};
            jump       = 1'b1;
            stage_next = STG_DONE;
          end
        end else begin
          jump       = 1'b1;
          stage_next = STG_DONE;
          if (status == ehp_pkg::PSTAT_OK) status_next = ehp_pkg::PSTAT_UNSUPP;
        end
      end

      STG_DONE: begin
        // Ignore trailing bytes until the frame ends
        adv = 1'b0;
      end

      default: begin
        adv        = 1'b0;
        stage_next = STG_DONE;
      end
    endcase

    // Advance the byte position, saturating at the top
    idx_next = idx;
    if (jump) idx_next = '0;
    else if (adv && idx != 7'd127) idx_next = idx + 7'd1;
  end

  // Status on the end record: a recorded status wins over truncation
  always_comb begin
    end_status = status_next;
    if (status_next == ehp_pkg::PSTAT_OK && stage_next != STG_DONE)
      end_status = ehp_pkg::PSTAT_TRUNC;
  end

  // Pack field and end record in wire order
  always_comb begin
    fld_res.tag    = fld_tag;
    fld_res.value  = fld_value;
    fld_res.status = ehp_pkg::PSTAT_OK;
    fld_res.last   = 1'b0;

    end_res.tag    = ehp_pkg::TAG_END;
    end_res.value  = '0;
    end_res.status = end_status;
    end_res.last   = 1'b1;

    if (fld_valid) begin
      batch.first  = fld_res;
      batch.second = end_res;
    end else begin
      batch.first  = end_res;
      batch.second = end_res;
    end
    batch.count = take ? ({1'b0, fld_valid} + {1'b0, frame_end}) : 2'd0;
  end

  // Hold parse state; frame end returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      stage  <= STG_ETH;
      idx    <= '0;
      facc   <= '0;
      ihb    <= '0;
      tkind  <= TK_NONE;
      status <= ehp_pkg::PSTAT_OK;
    end else if (take) begin
      if (frame_end) begin
        stage  <= STG_ETH;
        idx    <= '0;
        facc   <= '0;
        ihb    <= '0;
        tkind  <= TK_NONE;
        status <= ehp_pkg::PSTAT_OK;
      end else begin
        stage  <= stage_next;
        idx    <= idx_next;
        facc   <= acc;
        ihb    <= ihb_next;
        tkind  <= tkind_next;
        status <= status_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/ehp_outq.sv
// Result queue for the header parser: takes up to two results per cycle,
// hands out one per transfer. Depends on ehp_pkg for the result types.
`default_nettype none

module ehp_outq #(
  parameter int DEPTH = ehp_pkg::OUTQ_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ehp_pkg::ehp_batch_t  batch,
  input  wire logic                 pop,
  output ehp_pkg::ehp_result_t      head,
  output logic                      head_valid,
  output logic                      space
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  ehp_pkg::ehp_result_t entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr, wptr_p1, wptr_p2;
  logic [CNT_W-1:0] cnt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign wptr_p1    = ptr_inc(wptr);
  assign wptr_p2    = ptr_inc(wptr_p1);
  assign head       = entries[rptr];
  assign head_valid = (cnt != '0);
  assign space      = (cnt <= CNT_W'(DEPTH - 2));

  // Write the batch at the tail
  always_ff @(posedge clk) begin
    if (batch.count != 2'd0) entries[wptr] <= batch.first;
    if (batch.count == 2'd2) entries[wptr_p1] <= batch.second;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      unique case (batch.count)
        2'd1:    wptr <= wptr_p1;
        2'd2:    wptr <= wptr_p2;
        default: wptr <= wptr;
      endcase
      if (pop) rptr <= ptr_inc(rptr);
      cnt <= cnt + CNT_W'(batch.count) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### rtl/core/ethernet_ip_header_parser.sv
// Ethernet / 802.1Q / IPv4 / IPv6 / L4 header parser, one byte per transfer.
// A field is written into the result queue on the edge that takes its last byte.
// Throughput: one byte per cycle while the result queue has room for two results;
// the end record of a byte that also closes a field comes out right after it.
// Reset (rst, synchronous) clears the parse state and empties the result queue.
// Depends on ehp_pkg, ehp_in_if, ehp_out_if, ehp_parse and ehp_outq.
`default_nettype none

module ethernet_ip_header_parser #(
  parameter int OUTQ_DEPTH = ehp_pkg::OUTQ_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ehp_in_if.sink     frame_bytes,
  ehp_out_if.source  header_fields
);

  logic                 take;
  logic                 space;
  logic                 head_valid;
  logic                 pop;
  ehp_pkg::ehp_batch_t  batch;
  ehp_pkg::ehp_result_t head;

  // Accept a byte while the queue can absorb two results
  assign frame_bytes.ready = space;
  assign take = frame_bytes.valid && space;
  assign pop  = head_valid && header_fields.ready;

  ehp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (frame_bytes.data_byte),
    .frame_end (frame_bytes.frame_end),
    .batch     (batch)
  );

  ehp_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .batch      (batch),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .space      (space)
  );

  // Drive the result channel from the queue head
  assign header_fields.valid        = head_valid;
  assign header_fields.field_tag    = head.tag;
  assign header_fields.field_value  = head.value;
  assign header_fields.parse_status = head.status;
  assign header_fields.run_last     = head.last;

endmodule

`default_nettype wire

### tb/ehp_field_checker.sv
`timescale 1ns / 1ps
// Result scoreboard for the Ethernet/IP header parser: re-parses every accepted byte
// and checks each result transfer, in order, against the fields it should produce.
// Depends on ehp_pkg, ehp_in_if and ehp_out_if.
module ehp_field_checker (
  input  logic clk,
  input  logic rst,
  ehp_in_if    frame_mon,
  ehp_out_if   field_mon,
  output int   mismatches,
  output int   pending
);

  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {HS_ETH, HS_VLAN, HS_IP4, HS_IP6, HS_L4, HS_DONE} hdr_stage_e;
  typedef enum logic [2:0] {L4_NONE, L4_TCP, L4_UDP, L4_ICMP, L4_IGMP} l4_kind_e;

  // Parse state of the frame in flight
  hdr_stage_e  stage;
  logic [6:0]  byte_idx;
  logic [63:0] byte_window;
  logic [15:0] ether_type;
  logic [5:0]  ip_hdr_len;
  l4_kind_e    l4_kind;
  logic [1:0]  frame_status;

  ehp_pkg::ehp_result_t expected_fields[$];
  int          fail_tally = 0;

  assign mismatches = fail_tally;

  function automatic void clear_frame();
    stage        = HS_ETH;
    byte_idx     = '0;
    byte_window  = '0;
    ether_type   = '0;
    ip_hdr_len   = '0;
    l4_kind      = L4_NONE;
    frame_status = ehp_pkg::PSTAT_OK;
  endfunction

  function automatic void push_field(logic [4:0] tag, logic [63:0] value);
    ehp_pkg::ehp_result_t r;
    r.tag    = tag;
    r.value  = value;
    r.status = ehp_pkg::PSTAT_OK;
    r.last   = 1'b0;
    expected_fields.push_back(r);
  endfunction

  function automatic void enter_stage(hdr_stage_e next);
    stage    = next;
    byte_idx = '0;
  endfunction

  // Stop parsing; a status already recorded wins
  function automatic void halt_parse(logic [1:0] why);
    if (frame_status == ehp_pkg::PSTAT_OK) frame_status = why;
    enter_stage(HS_DONE);
  endfunction

  function automatic void route_ethertype(bit tag_allowed);
    if (ether_type == ehp_pkg::ETYPE_VLAN && tag_allowed) enter_stage(HS_VLAN);
    else if (ether_type == ehp_pkg::ETYPE_IPV4) enter_stage(HS_IP4);
    else if (ether_type == ehp_pkg::ETYPE_IPV6) enter_stage(HS_IP6);
    else halt_parse(ehp_pkg::PSTAT_UNSUPP);
  endfunction

  function automatic void enter_transport();
    if (l4_kind == L4_NONE) halt_parse(ehp_pkg::PSTAT_UNSUPP);
    else enter_stage(HS_L4);
  endfunction

  // Advance the parse by one byte and queue the fields it completes
  function automatic void parse_byte(logic [7:0] b, logic eof);
    logic [63:0] w;
    int unsigned i;
    bit          advance;
    logic [1:0]  end_status;
    ehp_pkg::ehp_result_t end_rec;
    byte_window = {byte_window[55:0], b};
    w       = byte_window;
    i       = byte_idx;
    advance = 1'b1;
    case (stage)
      HS_ETH: begin
        if (i == 5) push_field(ehp_pkg::TAG_DST_MAC, {16'h0, w[47:0]});
        else if (i == 11) push_field(ehp_pkg::TAG_SRC_MAC, {16'h0, w[47:0]});
        else if (i == 13) begin
          ether_type = w[15:0];
          route_ethertype(1'b1);
          advance = 1'b0;
        end
      end
      HS_VLAN: begin
        if (i == 1) push_field(ehp_pkg::TAG_VLAN_ID, {52'h0, w[11:0]});
        else if (i == 3) begin
          ether_type = w[15:0];
          route_ethertype(1'b0);
          advance = 1'b0;
        end
      end
      HS_IP4: begin
        if (i == 0) begin
          ip_hdr_len = {b[3:0], 2'b00};
          if (b[3:0] < ehp_pkg::IHL_MIN) frame_status = ehp_pkg::PSTAT_BAD_IHL;
        end else if (i == 3) push_field(ehp_pkg::TAG_TOTAL_LEN, {48'h0, w[15:0]});
        else if (i == 5) push_field(ehp_pkg::TAG_IDENT, {48'h0, w[15:0]});
        else if (i == 8) push_field(ehp_pkg::TAG_TTL, {56'h0, b});
        else if (i == 9) begin
          push_field(ehp_pkg::TAG_IP_PROTO, {56'h0, b});
          case (b)
            ehp_pkg::PROTO_TCP:  l4_kind = L4_TCP;
            ehp_pkg::PROTO_UDP:  l4_kind = L4_UDP;
            ehp_pkg::PROTO_ICMP: l4_kind = L4_ICMP;
            ehp_pkg::PROTO_IGMP: l4_kind = L4_IGMP;
            default:             l4_kind = L4_NONE;
          endcase
        end else if (i == 15) push_field(ehp_pkg::TAG_IP4_SRC, {32'h0, w[31:0]});
        else if (i == 19) push_field(ehp_pkg::TAG_IP4_DST, {32'h0, w[31:0]});
        // Skip options; a bad IHL ends the parse after the fixed header
        if (i >= 19) begin
          if (frame_status == ehp_pkg::PSTAT_BAD_IHL) begin
            enter_stage(HS_DONE);
            advance = 1'b0;
          end else if (i + 1 >= ip_hdr_len) begin
            enter_transport();
            advance = 1'b0;
          end
        end
      end
      HS_IP6: begin
        if (i == 5) push_field(ehp_pkg::TAG_PAYLOAD_LEN, {48'h0, w[15:0]});
        else if (i == 6) begin
          push_field(ehp_pkg::TAG_IP_PROTO, {56'h0, b});
          case (b)
            ehp_pkg::PROTO_TCP: l4_kind = L4_TCP;
            ehp_pkg::PROTO_UDP: l4_kind = L4_UDP;
            default:            l4_kind = L4_NONE;
          endcase
        end else if (i == 7) push_field(ehp_pkg::TAG_HOP_LIMIT, {56'h0, b});
        else if (i == 15) push_field(ehp_pkg::TAG_IP6_SRC_HI, w);
        else if (i == 23) push_field(ehp_pkg::TAG_IP6_SRC_LO, w);
        else if (i == 31) push_field(ehp_pkg::TAG_IP6_DST_HI, w);
        else if (i == 39) begin
          push_field(ehp_pkg::TAG_IP6_DST_LO, w);
          enter_transport();
          advance = 1'b0;
        end
      end
      HS_L4: begin
        case (l4_kind)
          L4_TCP, L4_UDP: begin
            if (i == 1) push_field(ehp_pkg::TAG_L4_SRC_PORT, {48'h0, w[15:0]});
            else if (i == 3) push_field(ehp_pkg::TAG_L4_DST_PORT, {48'h0, w[15:0]});
            else if (l4_kind == L4_UDP && i == 5) begin
              push_field(ehp_pkg::TAG_UDP_LEN, {48'h0, w[15:0]});
              enter_stage(HS_DONE);
              advance = 1'b0;
            end else if (l4_kind == L4_TCP && i == 12)
              push_field(ehp_pkg::TAG_TCP_HDR_LEN, {58'h0, b[7:4], 2'b00});
            else if (l4_kind == L4_TCP && i == 13)
              push_field(ehp_pkg::TAG_TCP_FLAGS, {56'h0, b});
            else if (l4_kind == L4_TCP && i == 15) begin
              push_field(ehp_pkg::TAG_TCP_WINDOW, {48'h0, w[15:0]});
              enter_stage(HS_DONE);
              advance = 1'b0;
            end
          end
          L4_ICMP: begin
            if (i == 0) push_field(ehp_pkg::TAG_ICMP_TYPE, {56'h0, b});
            else if (i == 1) begin
              push_field(ehp_pkg::TAG_ICMP_CODE, {56'h0, b});
              enter_stage(HS_DONE);
              advance = 1'b0;
            end
          end
          L4_IGMP: begin
            if (i == 0) push_field(ehp_pkg::TAG_IGMP_TYPE, {56'h0, b});
            else if (i == 7) begin
              push_field(ehp_pkg::TAG_IGMP_GROUP, {32'h0, w[31:0]});
              enter_stage(HS_DONE);
              advance = 1'b0;
            end
          end
          default: begin
            halt_parse(ehp_pkg::PSTAT_UNSUPP);
            advance = 1'b0;
          end
        endcase
      end
      default: begin
        stage   = HS_DONE;
        advance = 1'b0;
      end
    endcase
    if (advance && byte_idx != 7'd127) byte_idx = byte_idx + 7'd1;
    // Close the frame with its end record
    if (eof) begin
      end_status = frame_status;
      if (end_status == ehp_pkg::PSTAT_OK && stage != HS_DONE)
        end_status = ehp_pkg::PSTAT_TRUNC;
      end_rec.tag    = ehp_pkg::TAG_END;
      end_rec.value  = '0;
      end_rec.status = end_status;
      end_rec.last   = 1'b1;
      expected_fields.push_back(end_rec);
      clear_frame();
    end
  endfunction

  function automatic void log_failure(string msg);
    fail_tally++;
    if (fail_tally <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  function automatic void check_field(ehp_pkg::ehp_result_t seen);
    ehp_pkg::ehp_result_t want;
    if (expected_fields.size() == 0) begin
      log_failure($sformatf("unexpected result: tag %0d value %h status %0d last %0b",
                            seen.tag, seen.value, seen.status, seen.last));
    end else begin
      want = expected_fields.pop_front();
      if (seen.tag !== want.tag || seen.value !== want.value ||
          seen.status !== want.status || seen.last !== want.last)
        log_failure($sformatf({"result mismatch: expected tag %0d value %h status %0d ",
                               "last %0b, got tag %0d value %h status %0d last %0b"},
                              want.tag, want.value, want.status, want.last,
                              seen.tag, seen.value, seen.status, seen.last));
    end
  endfunction

  // Predict on each byte transfer, check on each result transfer
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      expected_fields.delete();
      pending <= 0;
    end else begin
      if (frame_mon.valid && frame_mon.ready)
        parse_byte(frame_mon.data_byte, frame_mon.frame_end);
      if (field_mon.valid && field_mon.ready)
        check_field({field_mon.field_tag, field_mon.field_value,
                     field_mon.parse_status, field_mon.run_last});
      pending <= expected_fields.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the header parser testbench: clock, reset, frame stimulus and result-side
// stalls; the verdict comes from the failure count of ehp_field_checker.
// Depends on ehp_pkg, ehp_in_if, ehp_out_if, ethernet_ip_header_parser, ehp_field_checker.
module testbench;

  localparam int HALF_PERIOD  = 6;
  localparam int RANDOM_BYTES = 900;
  localparam int STALL_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 6_000_000;

  typedef enum {NET_IP4, NET_IP6, NET_OTHER} net_kind_e;
  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         stall_request = 1'b0;
  int         mismatches;
  int         pending;
  int         counted_bytes = 0;
  logic [7:0] frame_buf[$];

  ehp_in_if  frame_ch ();
  ehp_out_if field_ch ();

  ethernet_ip_header_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .frame_bytes   (frame_ch),
    .header_fields (field_ch)
  );

  ehp_field_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .frame_mon  (frame_ch),
    .field_mon  (field_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [7:0] fill_byte(fill_e fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom_range(255));
    endcase
  endfunction

  // Assemble one frame: MACs, tags, ethertype, IP header with options, L4 header
  task automatic build_frame(input net_kind_e net, input logic [7:0] proto, input int tags,
                             input logic [3:0] ihl, input fill_e fill);
    int          l4_len;
    logic [15:0] etype;
    frame_buf.delete();
    repeat (12) frame_buf.push_back(fill_byte(fill));
    repeat (tags) begin
      frame_buf.push_back(ehp_pkg::ETYPE_VLAN[15:8]);
      frame_buf.push_back(ehp_pkg::ETYPE_VLAN[7:0]);
      repeat (2) frame_buf.push_back(fill_byte(fill));
    end
    case (net)
      NET_IP4: etype = ehp_pkg::ETYPE_IPV4;
      NET_IP6: etype = ehp_pkg::ETYPE_IPV6;
      default: begin
        etype = 16'($urandom_range(65535));
        if (etype == ehp_pkg::ETYPE_VLAN || etype == ehp_pkg::ETYPE_IPV4 ||
            etype == ehp_pkg::ETYPE_IPV6)
          etype = 16'h88CC;
      end
    endcase
    frame_buf.push_back(etype[15:8]);
    frame_buf.push_back(etype[7:0]);
    if (net == NET_IP4) begin
      frame_buf.push_back({4'($urandom_range(15)), ihl});
      for (int k = 1; k < 20; k++) frame_buf.push_back(k == 9 ? proto : fill_byte(fill));
      repeat (ihl > 5 ? 4 * (int'(ihl) - 5) : 0) frame_buf.push_back(fill_byte(fill));
    end else if (net == NET_IP6) begin
      for (int k = 0; k < 40; k++) frame_buf.push_back(k == 6 ? proto : fill_byte(fill));
    end
    if (net != NET_OTHER) begin
      case (proto)
        ehp_pkg::PROTO_TCP:  l4_len = 20;
        ehp_pkg::PROTO_ICMP: l4_len = 4;
        default:             l4_len = 8;
      endcase
      repeat (l4_len) frame_buf.push_back(fill_byte(fill));
    end
  endtask

  // Offer one byte, with random idle cycles ahead of it, and hold until transfer
  task automatic send_byte(input logic [7:0] value, input logic last_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frame_ch.valid     <= 1'b1;
    frame_ch.data_byte <= value;
    frame_ch.frame_end <= last_byte;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
  endtask

  // Send the built frame, cut to keep bytes if keep is nonzero, else with pad bytes
  task automatic send_frame(input int keep, input int pad);
    int total;
    repeat (pad) frame_buf.push_back(8'($urandom_range(255)));
    total = (keep > 0 && keep < frame_buf.size()) ? keep : frame_buf.size();
    for (int k = 0; k < total; k++) send_byte(frame_buf[k], k == total - 1);
  endtask

  // Mostly well-formed frames with random content, some broken or cut short
  task automatic random_frame(output int useful);
    net_kind_e  net;
    logic [7:0] proto;
    logic [3:0] ihl;
    int         tags;
    int         keep;
    int         roll;
    roll = $urandom_range(99);
    tags = roll < 70 ? 0 : roll < 95 ? 1 : 2;
    roll = $urandom_range(99);
    net  = roll < 55 ? NET_IP4 : roll < 90 ? NET_IP6 : NET_OTHER;
    roll = $urandom_range(99);
    if (roll < 22) proto = ehp_pkg::PROTO_TCP;
    else if (roll < 44) proto = ehp_pkg::PROTO_UDP;
    else if (roll < 66) proto = ehp_pkg::PROTO_ICMP;
    else if (roll < 88) proto = ehp_pkg::PROTO_IGMP;
    else proto = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 60) ihl = ehp_pkg::IHL_MIN;
    else if (roll < 90) ihl = 4'($urandom_range(15, 6));
    else ihl = 4'($urandom_range(4, 0));
    build_frame(net, proto, tags, ihl, FILL_RAND);
    keep   = ($urandom_range(99) < 15) ? $urandom_range(frame_buf.size(), 1) : 0;
    useful = keep > 0 ? keep : frame_buf.size();
    send_frame(keep, $urandom_range(4, 0));
  endtask

  // Pause the sender until every expected result has come
  task automatic wait_drained();
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Drive ready: random stalls, plus one long hold-off on request
  initial begin
    int held;
    held = 0;
    field_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        held = STALL_CYCLES;
      end
      if (held > 0) begin
        field_ch.ready <= 1'b0;
        held--;
      end else begin
        field_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus: reset, directed frames, then random frames over four idling phases
  initial begin
    int useful;
    frame_ch.valid     = 1'b0;
    frame_ch.data_byte = 8'h00;
    frame_ch.frame_end = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every protocol, all-ones and all-zero fields
    build_frame(NET_IP4, ehp_pkg::PROTO_TCP, 0, ehp_pkg::IHL_MIN, FILL_ONES);
    send_frame(0, 0);
    build_frame(NET_IP4, ehp_pkg::PROTO_UDP, 0, ehp_pkg::IHL_MIN, FILL_ZERO);
    send_frame(0, 0);
    // Trailing bytes after a complete ICMP header are ignored
    build_frame(NET_IP4, ehp_pkg::PROTO_ICMP, 1, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(0, 3);
    // Longest option area
    build_frame(NET_IP4, ehp_pkg::PROTO_IGMP, 0, 4'd15, FILL_ONES);
    send_frame(0, 0);
    build_frame(NET_IP6, ehp_pkg::PROTO_TCP, 1, ehp_pkg::IHL_MIN, FILL_ONES);
    send_frame(0, 0);
    build_frame(NET_IP6, ehp_pkg::PROTO_UDP, 0, ehp_pkg::IHL_MIN, FILL_ZERO);
    send_frame(0, 0);
    // Unsupported: ICMP over IPv6, unknown protocol, unknown ethertype, second tag
    build_frame(NET_IP6, ehp_pkg::PROTO_ICMP, 0, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(0, 0);
    build_frame(NET_IP4, 8'd47, 0, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(0, 2);
    build_frame(NET_OTHER, ehp_pkg::PROTO_TCP, 0, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(0, 4);
    build_frame(NET_IP4, ehp_pkg::PROTO_TCP, 2, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(0, 0);
    // Bad IHL: zero, one below minimum, and cut short inside the fixed header
    build_frame(NET_IP4, ehp_pkg::PROTO_UDP, 0, 4'd0, FILL_ONES);
    send_frame(0, 0);
    build_frame(NET_IP4, ehp_pkg::PROTO_TCP, 0, 4'd4, FILL_RAND);
    send_frame(0, 0);
    build_frame(NET_IP4, ehp_pkg::PROTO_TCP, 0, 4'd3, FILL_RAND);
    send_frame(25, 0);
    // Truncated: inside the IPv4 header, single-byte frame, inside UDP over IPv6
    build_frame(NET_IP4, ehp_pkg::PROTO_TCP, 0, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(30, 0);
    build_frame(NET_IP4, ehp_pkg::PROTO_TCP, 0, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(1, 0);
    build_frame(NET_IP6, ehp_pkg::PROTO_UDP, 0, ehp_pkg::IHL_MIN, FILL_RAND);
    send_frame(60, 0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // Hold off the result side while a long frame streams in back to back
      if (phase == 0) begin
        stall_request = 1'b1;
        build_frame(NET_IP4, ehp_pkg::PROTO_TCP, 1, 4'd15, FILL_RAND);
        send_frame(0, 0);
      end
      while (counted_bytes < (phase + 1) * RANDOM_BYTES / 4) begin
        random_frame(useful);
        counted_bytes += useful;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
